FILE: hdl/hmsbs_pkg.sv
// Shared types and constants for the height map scale and box smoothing block.
package hmsbs_pkg;

	localparam int RAW_W    = 8;   // raw height byte
	localparam int HGT_W    = 16;  // Q8.8 height
	localparam int PROD_W   = 24;  // raw * max_height
	localparam int QUO0_W   = 17;  // first quotient estimate of prod / 255
	localparam int REMS_W   = 10;  // remainder of that estimate, below 3*255
	localparam int ROWSUM_W = 18;  // three heights
	localparam int SUM_W    = 20;  // nine heights
	localparam int DIV_W    = 4;   // neighbor count, 1..9
	localparam int STEP_W   = 5;   // divider step counter
	localparam int ROW_W    = 12;  // row counter
	localparam int IMGW_W   = 9;   // image_width register
	localparam int IMGH_W   = 13;  // image_height register
	localparam int CFG_AW   = 2;   // register index
	localparam int CFG_DW   = 16;  // widest register

	localparam logic [IMGH_W-1:0] MAX_ROWS = IMGH_W'(4096);

	// register indexes
	localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MAX_HEIGHT    = 2'd2;
	localparam logic [CFG_AW-1:0] REG_SMOOTH_ENABLE = 2'd3;

	// reset values of the registers
	localparam logic [IMGW_W-1:0] RST_IMAGE_WIDTH   = 9'd256;
	localparam logic [IMGH_W-1:0] RST_IMAGE_HEIGHT  = 13'd256;
	localparam logic [HGT_W-1:0]  RST_MAX_HEIGHT    = 16'd256;
	localparam logic              RST_SMOOTH_ENABLE = 1'b1;

	// input kind on tuser
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_QUO  = 8'b0000_0010,
		S_REM  = 8'b0000_0100,
		S_WIN  = 8'b0000_1000,
		S_ROWS = 8'b0001_0000,
		S_SUM  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_EMIT = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic load;   // beat accepted: latch product, read line stores
		logic quo;    // quotient estimate
		logic rem;    // remainder of the estimate
		logic win;    // final scaled height, line store write, window shift
		logic rows;   // masked row sums and neighbor count
		logic sum;    // total, start divider
		logic emit;   // load output register, advance position
	} cmd_t;

	typedef struct packed {
		logic priming;
		logic smooth;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/hmsbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hmsbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hdl/hmsbs_div.sv
// Restoring divider, one quotient bit per cycle, for the neighborhood mean.
module hmsbs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hmsbs_pkg::SUM_W-1:0]  dividend,
	input  logic [hmsbs_pkg::DIV_W-1:0]  divisor,
	output logic                         done,
	output logic [hmsbs_pkg::SUM_W-1:0]  quotient
);

	logic [hmsbs_pkg::STEP_W-1:0] step_q;
	logic [hmsbs_pkg::SUM_W-1:0]  quo_q;
	logic [hmsbs_pkg::DIV_W-1:0]  rem_q;
	logic [hmsbs_pkg::DIV_W-1:0]  dsr_q;
	logic [hmsbs_pkg::DIV_W:0]    rem_shift;
	logic                         fits;

	assign rem_shift = {rem_q, quo_q[hmsbs_pkg::SUM_W-1]};
	assign fits      = rem_shift >= {1'b0, dsr_q};
	assign done      = step_q == '0;
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= hmsbs_pkg::STEP_W'(hmsbs_pkg::SUM_W);
		end else if (!done) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (!done) begin
			quo_q <= {quo_q[hmsbs_pkg::SUM_W-2:0], fits};
			if (fits) begin
				rem_q <= hmsbs_pkg::DIV_W'(rem_shift - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_shift[hmsbs_pkg::DIV_W-1:0];
			end
		end
	end

endmodule

FILE: hdl/hmsbs_ctrl.sv
// Sequencer for one beat: scale, line store update, window sums, divide, output.
module hmsbs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  hmsbs_pkg::sts_t   sts,
	output hmsbs_pkg::cmd_t   cmd
);

	hmsbs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmsbs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hmsbs_pkg::S_IDLE: begin
				if (s_tvalid) state_d = hmsbs_pkg::S_QUO;
			end
			hmsbs_pkg::S_QUO:  state_d = hmsbs_pkg::S_REM;
			hmsbs_pkg::S_REM:  state_d = hmsbs_pkg::S_WIN;
			hmsbs_pkg::S_WIN: begin
				if (sts.priming)     state_d = hmsbs_pkg::S_IDLE;
				else if (sts.smooth) state_d = hmsbs_pkg::S_ROWS;
				else                 state_d = hmsbs_pkg::S_EMIT;
			end
			hmsbs_pkg::S_ROWS: state_d = hmsbs_pkg::S_SUM;
			hmsbs_pkg::S_SUM:  state_d = hmsbs_pkg::S_DIV;
			hmsbs_pkg::S_DIV: begin
				if (sts.div_done) state_d = hmsbs_pkg::S_EMIT;
			end
			hmsbs_pkg::S_EMIT: begin
				if (sts.out_free) state_d = hmsbs_pkg::S_IDLE;
			end
			default: state_d = hmsbs_pkg::S_IDLE;
		endcase
	end

	assign s_tready = state_q == hmsbs_pkg::S_IDLE;

	always_comb begin
		cmd.load = (state_q == hmsbs_pkg::S_IDLE) && s_tvalid;
		cmd.quo  = state_q == hmsbs_pkg::S_QUO;
		cmd.rem  = state_q == hmsbs_pkg::S_REM;
		cmd.win  = state_q == hmsbs_pkg::S_WIN;
		cmd.rows = state_q == hmsbs_pkg::S_ROWS;
		cmd.sum  = state_q == hmsbs_pkg::S_SUM;
		cmd.emit = (state_q == hmsbs_pkg::S_EMIT) && sts.out_free;
	end

endmodule

FILE: hdl/hmsbs_dp.sv
// Datapath: registers, scaling, two line stores, 3x3 window, mean and output register.
module hmsbs_dp #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hmsbs_pkg::cmd_t                cmd,
	output hmsbs_pkg::sts_t                sts,
	input  logic                           cfg_wr_en,
	input  logic [hmsbs_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [hmsbs_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic                           mode,
	input  logic [hmsbs_pkg::RAW_W-1:0]    raw_height,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hmsbs_pkg::HGT_W-1:0]    smoothed_height,
	output logic                           last_pixel
);

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int CW  = ($clog2(MAX_WIDTH + 1) > hmsbs_pkg::IMGW_W) ?
		$clog2(MAX_WIDTH + 1) : hmsbs_pkg::IMGW_W;
	localparam int XW  = CW + 1;
	localparam int EW  = $clog2(MAX_WIDTH + 2);
	localparam int HW  = hmsbs_pkg::HGT_W;

	// configuration
	logic [hmsbs_pkg::IMGW_W-1:0] width_q;
	logic [hmsbs_pkg::IMGH_W-1:0] height_q;
	logic [HW-1:0]                maxh_q;
	logic                         smooth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= hmsbs_pkg::RST_IMAGE_WIDTH;
			height_q <= hmsbs_pkg::RST_IMAGE_HEIGHT;
			maxh_q   <= hmsbs_pkg::RST_MAX_HEIGHT;
			smooth_q <= hmsbs_pkg::RST_SMOOTH_ENABLE;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				hmsbs_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_wdata[hmsbs_pkg::IMGW_W-1:0];
				hmsbs_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_wdata[hmsbs_pkg::IMGH_W-1:0];
				hmsbs_pkg::REG_MAX_HEIGHT:    maxh_q   <= cfg_wdata[HW-1:0];
				hmsbs_pkg::REG_SMOOTH_ENABLE: smooth_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [CW-1:0]                w_eff;
	logic [hmsbs_pkg::IMGH_W-1:0] h_eff;

	always_comb begin
		if (width_q == '0)                         w_eff = CW'(1);
		else if (CW'(width_q) > CW'(MAX_WIDTH))    w_eff = CW'(MAX_WIDTH);
		else                                       w_eff = CW'(width_q);
		if (height_q == '0)                        h_eff = hmsbs_pkg::IMGH_W'(1);
		else if (height_q > hmsbs_pkg::MAX_ROWS)   h_eff = hmsbs_pkg::MAX_ROWS;
		else                                       h_eff = height_q;
	end

	// position of the next pixel to emit
	logic [AW-1:0]                  col_q;
	logic [hmsbs_pkg::ROW_W-1:0]    row_q;
	logic [EW-1:0]                  prime_q;
	logic [AW:0]                    col_inc;
	logic [hmsbs_pkg::IMGH_W-1:0]   row_inc;
	logic                           priming;
	logic                           last_col;
	logic                           last_row;
	logic [AW-1:0]                  addr;

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign priming  = XW'(prime_q) < (XW'(w_eff) + XW'(1));
	assign last_col = XW'(col_inc) >= XW'(w_eff);
	assign last_row = row_inc >= h_eff;

	always_comb begin
		if (priming) begin
			addr = (XW'(prime_q) >= XW'(w_eff)) ? '0 : prime_q[AW-1:0];
		end else begin
			addr = last_col ? '0 : col_inc[AW-1:0];
		end
	end

	// scaling: prod / 255 as prod * 257 / 65536, then up to two corrections
	logic [AW-1:0]                 addr_q;
	logic [hmsbs_pkg::PROD_W-1:0]  prod_s1;
	logic [hmsbs_pkg::QUO0_W-1:0]  q0_s2;
	logic [hmsbs_pkg::QUO0_W-1:0]  q0_s3;
	logic [hmsbs_pkg::REMS_W-1:0]  rem_s3;
	logic [hmsbs_pkg::PROD_W+8:0]  prod_x257;
	logic [hmsbs_pkg::PROD_W+1:0]  rem_full;
	logic [1:0]                    corr;
	logic [hmsbs_pkg::QUO0_W-1:0]  val_full;
	logic [HW-1:0]                 val;

	assign prod_x257 = (hmsbs_pkg::PROD_W+9)'(prod_s1)
		+ {1'b0, prod_s1, 8'd0};
	assign rem_full  = (hmsbs_pkg::PROD_W+2)'(prod_s1)
		- ({(hmsbs_pkg::PROD_W+2-hmsbs_pkg::QUO0_W-8)'(0), q0_s2, 8'd0}
		- (hmsbs_pkg::PROD_W+2)'(q0_s2));

	always_comb begin
		if (rem_s3 >= hmsbs_pkg::REMS_W'(510))      corr = 2'd2;
		else if (rem_s3 >= hmsbs_pkg::REMS_W'(255)) corr = 2'd1;
		else                                        corr = 2'd0;
	end

	assign val_full = q0_s3 + hmsbs_pkg::QUO0_W'(corr);
	assign val      = val_full[HW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q  <= addr;
			prod_s1 <= (mode == hmsbs_pkg::MODE_FLUSH) ? '0 :
				hmsbs_pkg::PROD_W'(raw_height) * hmsbs_pkg::PROD_W'(maxh_q);
		end
		if (cmd.quo) begin
			q0_s2 <= prod_x257[hmsbs_pkg::PROD_W+8:16];
		end
		if (cmd.rem) begin
			q0_s3  <= q0_s2;
			rem_s3 <= rem_full[hmsbs_pkg::REMS_W-1:0];
		end
	end

	// line stores: row above in line_a, two rows above in line_b
	logic [HW-1:0] a_rd;
	logic [HW-1:0] b_rd;

	hmsbs_ram #(.WIDTH(HW), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk     (clk),
		.wr_en   (cmd.win),
		.wr_addr (addr_q),
		.wr_data (val),
		.rd_en   (cmd.load),
		.rd_addr (addr),
		.rd_data (a_rd)
	);

	hmsbs_ram #(.WIDTH(HW), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk     (clk),
		.wr_en   (cmd.win),
		.wr_addr (addr_q),
		.wr_data (a_rd),
		.rd_en   (cmd.load),
		.rd_addr (addr),
		.rd_data (b_rd)
	);

	// 3x3 window, row 0 oldest, column 2 newest
	logic [HW-1:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[r][k] <= '0;
				end
			end
		end else if (cmd.win) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= b_rd;
			win_q[1][2] <= a_rd;
			win_q[2][2] <= val;
		end
	end

	// neighborhood sums over in-bounds cells
	logic [2:0]                      rv;
	logic [2:0]                      cv;
	logic [1:0]                      nr;
	logic [1:0]                      nc;
	logic [hmsbs_pkg::ROWSUM_W-1:0]  rsum [3];
	logic [hmsbs_pkg::ROWSUM_W-1:0]  rsum_s1 [3];
	logic [hmsbs_pkg::DIV_W-1:0]     cnt_s1;
	logic [hmsbs_pkg::SUM_W-1:0]     total;

	assign rv = {!last_row, 1'b1, row_q != '0};
	assign cv = {!last_col, 1'b1, col_q != '0};
	assign nr = 2'd1 + 2'(rv[0]) + 2'(rv[2]);
	assign nc = 2'd1 + 2'(cv[0]) + 2'(cv[2]);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rsum[r] = '0;
			if (rv[r]) begin
				for (int k = 0; k < 3; k++) begin
					if (cv[k]) rsum[r] = rsum[r] + hmsbs_pkg::ROWSUM_W'(win_q[r][k]);
				end
			end
		end
	end

	assign total = hmsbs_pkg::SUM_W'(rsum_s1[0]) + hmsbs_pkg::SUM_W'(rsum_s1[1])
		+ hmsbs_pkg::SUM_W'(rsum_s1[2]);

	always_ff @(posedge clk) begin
		if (cmd.rows) begin
			for (int r = 0; r < 3; r++) begin
				rsum_s1[r] <= rsum[r];
			end
			cnt_s1 <= hmsbs_pkg::DIV_W'(nr) * hmsbs_pkg::DIV_W'(nc);
		end
	end

	logic                         div_done;
	logic [hmsbs_pkg::SUM_W-1:0]  div_quo;

	hmsbs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sum),
		.dividend (total),
		.divisor  (cnt_s1),
		.done     (div_done),
		.quotient (div_quo)
	);

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			prime_q <= '0;
		end else if (cmd.win && priming) begin
			prime_q <= prime_q + 1'b1;
		end else if (cmd.emit) begin
			if (last_col && last_row) begin
				col_q   <= '0;
				row_q   <= '0;
				prime_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_inc[hmsbs_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[AW-1:0];
			end
		end
	end

	// output register; a new beat may be loaded as the old one leaves
	logic out_free;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			smoothed_height <= smooth_q ? div_quo[HW-1:0] : win_q[1][1];
			last_pixel      <= last_col && last_row;
		end
	end

	assign sts.priming  = priming;
	assign sts.smooth   = smooth_q;
	assign sts.div_done = div_done;
	assign sts.out_free = out_free;

endmodule

FILE: hdl/heightmap_scale_and_box_smooth_top.sv
// Top level of the height map scaler with 3x3 box mean smoothing.
// Raw height bytes enter in raster order and are scaled to raw*max_height/255 (Q8.8,
// truncated); with smoothing on, each pixel becomes the truncated mean of its in-bounds
// 3x3 neighborhood. A pixel's result leaves with input beat p + W + 1, so W + 1 flush
// beats (tuser = 1) drain a map; tlast marks its final pixel. One beat is worked at a
// time, and with smoothing on its result also waits for the 20-step bit-serial divider
// for the mean. The output register lets the next beat enter while a result waits. The
// line stores need no clearing pass after reset. Configuration is to be written only
// while the block is idle; the block itself does not enforce this.
module heightmap_scale_and_box_smooth_top #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] raw_height
	input  logic [0:0]                    s_tuser,   // [0] mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [15:0] smoothed_height
	output logic                          m_tlast,
	input  logic                          cfg_wr_en,
	input  logic [hmsbs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [hmsbs_pkg::CFG_DW-1:0]  cfg_wdata
);

	hmsbs_pkg::cmd_t cmd;
	hmsbs_pkg::sts_t sts;

	hmsbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hmsbs_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.mode            (s_tuser[0]),
		.raw_height      (s_tdata[hmsbs_pkg::RAW_W-1:0]),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.smoothed_height (m_tdata),
		.last_pixel      (m_tlast)
	);

	// sequencer issues at most one step per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.quo, cmd.rem, cmd.win, cmd.rows, cmd.sum, cmd.emit}))
		else $error("more than one datapath step in a cycle");

	// an accepted beat always moves on to the quotient step
	a_load_then_quo: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.quo)
		else $error("accepted beat not followed by scaling");

	// a result is never loaded over one that has not left
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

	// the mean is only taken once the divider has finished
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.smooth) |-> sts.div_done)
		else $error("mean emitted before divider finished");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the height map scaler with 3x3 box mean smoothing.
module tb_top;
	import hmsbs_pkg::*;

	localparam int LINE_LEN     = 256;  // MAX_WIDTH of the instance
	localparam int SETTLE       = 40;   // beyond the slowest beat of the block
	localparam int MAX_GAP      = 13;
	localparam int RANDOM_ITEMS = 250;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [HGT_W-1:0] height;
		logic             last;
	} pixel_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;    // [7:0] raw_height
	logic [0:0]        s_tuser;    // [0] mode
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;    // [15:0] smoothed_height
	logic              m_tlast;
	logic              cfg_wr_en;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;

	// predictor state
	logic [IMGW_W-1:0] map_width;
	logic [IMGH_W-1:0] map_rows;
	logic [HGT_W-1:0]  peak_height;
	logic              smooth_on;
	logic [HGT_W-1:0]  line_mem [0:2*LINE_LEN-1];
	logic [HGT_W-1:0]  win [0:8];
	int unsigned       col_pos;
	int unsigned       row_pos;
	int unsigned       prime_cnt;

	pixel_t      pending_pixels[$];
	int unsigned mismatches;
	int unsigned items_sent;
	bit          gaps_on;
	int unsigned sink_hold;

	heightmap_scale_and_box_smooth_top #(
		.MAX_WIDTH(LINE_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned cols_in_use();
		if (map_width == 0) return 1;
		if (map_width > LINE_LEN) return LINE_LEN;
		return map_width;
	endfunction

	function automatic int unsigned rows_in_use();
		if (map_rows == 0) return 1;
		if (map_rows > MAX_ROWS) return MAX_ROWS;
		return map_rows;
	endfunction

	// One beat through the scaler and window; returns 1 when it yields a pixel.
	function automatic bit scale_and_smooth(input logic md, input logic [RAW_W-1:0] raw,
			output pixel_t px);
		int unsigned w, h, addr, sum, cnt, r, k;
		logic [HGT_W-1:0] val;
		bit priming, last_col, last_row;
		bit rv[3];
		bit cv[3];
		w = cols_in_use();
		h = rows_in_use();
		val = (md == MODE_SAMPLE) ? HGT_W'((32'(raw) * 32'(peak_height)) / 32'd255) : '0;
		priming = prime_cnt < w + 1;
		px = '0;
		if (priming)
			addr = (prime_cnt >= w) ? 0 : prime_cnt;
		else
			addr = (col_pos + 1 >= w) ? 0 : col_pos + 1;
		addr = addr % LINE_LEN;

		for (r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = line_mem[LINE_LEN + addr];
		win[5] = line_mem[addr];
		win[8] = val;
		line_mem[LINE_LEN + addr] = line_mem[addr];
		line_mem[addr] = val;

		if (priming) begin
			prime_cnt++;
			return 1'b0;
		end

		last_col = col_pos + 1 >= w;
		last_row = row_pos + 1 >= h;
		if (smooth_on) begin
			// only in-bounds neighbors count toward the mean
			rv[0] = row_pos > 0;
			rv[1] = 1'b1;
			rv[2] = !last_row;
			cv[0] = col_pos > 0;
			cv[1] = 1'b1;
			cv[2] = !last_col;
			sum = 0;
			cnt = 0;
			for (r = 0; r < 3; r++)
				for (k = 0; k < 3; k++)
					if (rv[r] && cv[k]) begin
						sum += win[r*3+k];
						cnt++;
					end
			px.height = HGT_W'(sum / cnt);
		end else begin
			px.height = win[4];
		end
		px.last = last_col && last_row;

		if (last_col && last_row) begin
			col_pos = 0;
			row_pos = 0;
			prime_cnt = 0;
		end else if (last_col) begin
			col_pos = 0;
			row_pos = (row_pos + 1) & 32'hFFF;
		end else begin
			col_pos = (col_pos + 1) & 32'hFF;
		end
		return 1'b1;
	endfunction

	function automatic void log_mismatch(input string what, input pixel_t want,
			input pixel_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s: expected height %h last %b, got height %h last %b",
				$time, what, want.height, want.last, got.height, got.last);
	endfunction

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				log_mismatch("unexpected beat", '0, {m_tdata, m_tlast});
			end else begin
				want = pending_pixels.pop_front();
				if (want.height !== m_tdata || want.last !== m_tlast)
					log_mismatch("pixel mismatch", want, {m_tdata, m_tlast});
			end
		end
	end

	// output side: random stalls, plus a long hold-off when one is requested
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	// tvalid is only lowered ahead of a gap, so back-to-back beats keep it high.
	task automatic send_item(input logic md, input logic [RAW_W-1:0] raw);
		int unsigned gap;
		pixel_t px;
		gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		s_tuser  <= md;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (scale_and_smooth(md, raw, px))
			pending_pixels.push_back(px);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= CFG_DW'(value);
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH:   map_width   = IMGW_W'(value);
			REG_IMAGE_HEIGHT:  map_rows    = IMGH_W'(value);
			REG_MAX_HEIGHT:    peak_height = HGT_W'(value);
			REG_SMOOTH_ENABLE: smooth_on   = value[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h,
			input int unsigned peak, input int unsigned smooth);
		wait_drained();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_MAX_HEIGHT, peak);
		write_reg(REG_SMOOTH_ENABLE, smooth);
		cfg_wr_en <= 1'b0;
	endtask

	// well-formed map at the current geometry: all samples, then the drain
	task automatic send_map();
		int unsigned w, h;
		w = cols_in_use();
		h = rows_in_use();
		repeat (w * h) send_item(MODE_SAMPLE, 8'($urandom_range(0, 255)));
		repeat (w + 1) send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
	endtask

	// flush until the current map has emitted its last pixel
	task automatic close_map();
		while (prime_cnt != 0) send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
	endtask

	// width 511 clamps to full width; two such rows fill both line stores
	task automatic test_full_width();
		configure(511, 2, 16'h1234, 1);
		send_map();
	endtask

	task automatic test_field_extremes();
		logic [7:0] checker_raw [9] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
			8'h00, 8'hFF, 8'h00, 8'hFF};
		int unsigned i;
		configure(3, 3, 16'hFFFF, 1);
		for (i = 0; i < 9; i++) send_item(MODE_SAMPLE, checker_raw[i]);
		for (i = 0; i < 4; i++) send_item(MODE_FLUSH, i[0] ? 8'h00 : 8'hFF);
		configure(2, 2, 16'hFFFF, 0);
		send_item(MODE_SAMPLE, 8'hFF);
		send_item(MODE_SAMPLE, 8'h00);
		send_item(MODE_SAMPLE, 8'h00);
		send_item(MODE_SAMPLE, 8'hFF);
		repeat (3) send_item(MODE_FLUSH, 8'h00);
		configure(2, 1, 0, 1);
		send_item(MODE_SAMPLE, 8'hFF);
		send_item(MODE_SAMPLE, 8'h80);
		repeat (3) send_item(MODE_FLUSH, 8'hFF);
	endtask

	// height 0 runs as one row; width 0 runs as one column, and a height of 8191
	// keeps going well past the first rows until it is cut short
	task automatic test_out_of_range_geometry();
		configure(9, 0, 16'hFFFF, 1);
		send_map();
		configure(0, 8191, 300, 1);
		repeat (40) send_item(MODE_SAMPLE, 8'($urandom_range(0, 255)));
		configure(0, 48, 300, 1);
		close_map();
	endtask

	task automatic test_thin_maps();
		configure(1, 1, 16'h0100, 1);
		send_map();
		configure(1, 5, 16'h8000, 1);
		send_map();
		configure(7, 1, 16'h4321, 1);
		send_map();
		configure(2, 2, 16'hABCD, 1);
		send_map();
	endtask

	// next map starts right after the drain, with no register write between
	task automatic test_back_to_back_maps();
		configure(4, 3, 16'h2000, 1);
		send_map();
		send_map();
		repeat (3) send_item(MODE_SAMPLE, 8'($urandom_range(0, 255)));
		close_map();
	endtask

	task automatic test_geometry_change_mid_map();
		configure(6, 4, 1000, 1);
		repeat (10) send_item(MODE_SAMPLE, 8'($urandom_range(0, 255)));
		configure(3, 2, 40000, 0);
		close_map();
		configure(5, 3, 777, 1);
		repeat (8) send_item(MODE_SAMPLE, 8'($urandom_range(0, 255)));
		configure(9, 3, 777, 1);
		close_map();
	endtask

	task automatic test_backpressure();
		configure(5, 4, 16'h7FFF, 1);
		gaps_on = 1'b0;
		sink_hold = 400;
		send_map();
		gaps_on = 1'b1;
	endtask

	task automatic test_source_pause();
		configure(4, 4, 16'h0555, 1);
		repeat (9) send_item(MODE_SAMPLE, 8'($urandom_range(0, 255)));
		wait_drained();
		repeat (7) send_item(MODE_SAMPLE, 8'($urandom_range(0, 255)));
		repeat (5) send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_random_maps();
		int unsigned target, w;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if ($urandom_range(0, 3) != 0) begin
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
				configure(w, $urandom_range(1, 6), $urandom_range(0, 65535),
					$urandom_range(0, 1));
			end
			gaps_on = ($urandom_range(0, 7) != 0);
			if ($urandom_range(0, 9) == 0)
				sink_hold = $urandom_range(50, 300);
			if ($urandom_range(0, 4) != 0) begin
				send_map();
			end else begin
				// broken map: random kinds, then drain whatever is left
				repeat ($urandom_range(1, 2 * cols_in_use() * rows_in_use()))
					send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				close_map();
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = MODE_SAMPLE;
		cfg_wr_en   = 1'b0;
		cfg_addr    = REG_IMAGE_WIDTH;
		cfg_wdata   = '0;
		map_width   = RST_IMAGE_WIDTH;
		map_rows    = RST_IMAGE_HEIGHT;
		peak_height = RST_MAX_HEIGHT;
		smooth_on   = RST_SMOOTH_ENABLE;
		foreach (line_mem[i]) line_mem[i] = '0;
		foreach (win[i]) win[i] = '0;
		col_pos     = 0;
		row_pos     = 0;
		prime_cnt   = 0;
		mismatches  = 0;
		items_sent  = 0;
		gaps_on     = 1'b1;
		sink_hold   = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_full_width();
		test_field_extremes();
		test_thin_maps();
		test_back_to_back_maps();
		test_geometry_change_mid_map();
		test_backpressure();
		test_source_pause();
		test_out_of_range_geometry();
		test_random_maps();

		wait_drained();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: heightmap_scale_and_box_smooth_top.f
hdl/hmsbs_pkg.sv
hdl/hmsbs_ram.sv
hdl/hmsbs_div.sv
hdl/hmsbs_ctrl.sv
hdl/hmsbs_dp.sv
hdl/heightmap_scale_and_box_smooth_top.sv
verif/tb_top.sv
